>>> rtl/rcpm_pkg.sv
// Shared constants and types of the RMS current and power meter.
`timescale 1ns / 1ps
`default_nettype none
package rcpm_pkg;

	localparam int unsigned SAMPLE_W   = 10;
	localparam int unsigned WLEN_W     = 8;
	localparam int unsigned CENTER_W   = 11;
	localparam int unsigned GAIN_W     = 16;
	localparam int unsigned VOLT_W     = 10;
	localparam int unsigned PF_W       = 11;
	localparam int unsigned AMPS_W     = 8;
	localparam int unsigned Q8_W       = 16;
	localparam int unsigned POWER_W    = 18;
	localparam int unsigned SUM_W      = 23;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [WLEN_W-1:0]   WLEN_RST   = 8'd117;
	localparam logic [CENTER_W-1:0] CENTER_RST = 11'd1023;
	localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd18123;
	localparam logic [VOLT_W-1:0]   VOLT_RST   = 10'd220;
	localparam logic [PF_W-1:0]     PF_RST     = 11'd942;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LEN   = 3'd0,
		REG_CENTER_X2    = 3'd1,
		REG_GAIN_Q16     = 3'd2,
		REG_LINE_VOLTAGE = 3'd3,
		REG_POWER_FACTOR = 3'd4
	} cfg_reg_t;

endpackage
`default_nettype wire

>>> rtl/rcpm_if.sv
// Sample and result channel interfaces of the RMS current and power meter.
`timescale 1ns / 1ps
`default_nettype none
interface rcpm_sample_if;
	logic                           valid;
	logic                           ready;
	logic [rcpm_pkg::SAMPLE_W-1:0]  sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface rcpm_result_if;
	logic                          valid;
	logic                          ready;
	logic [rcpm_pkg::AMPS_W-1:0]   irms_amps;
	logic [rcpm_pkg::Q8_W-1:0]     irms_q8;
	logic [rcpm_pkg::POWER_W-1:0]  power_watts;

	modport source (output valid, output irms_amps, output irms_q8, output power_watts,
		input ready);
	modport sink (input valid, input irms_amps, input irms_q8, input power_watts,
		output ready);
endinterface
`default_nettype wire

>>> rtl/rms_current_power_meter_core.sv
// RMS current and power meter core: bit-serial multiply, divide and square root.
// A sample is taken only when the core is idle; a sample that does not close the window
// keeps it busy for a gain multiply, then a squaring multiply, each taking one multiplier
// bit a cycle until no set bit is left. A window-closing sample adds a divide, a square
// root and two power multiplies, and its result waits in the output state while the
// previous result is unaccepted.
`timescale 1ns / 1ps
`default_nettype none
module rms_current_power_meter_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rcpm_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [rcpm_pkg::CFG_DATA_W-1:0]   cfg_data,
	rcpm_sample_if.sink                       samples,
	rcpm_result_if.source                     results
);

	localparam int unsigned ACC_W = 40;
	localparam int unsigned MPL_W = 18;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_MGAIN  = 9'b000000010,
		ST_SQUARE = 9'b000000100,
		ST_DIV    = 9'b000001000,
		ST_SQRT   = 9'b000010000,
		ST_MVOLT  = 9'b000100000,
		ST_MPF    = 9'b001000000,
		ST_OUT    = 9'b010000000,
		ST_SPARE  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [rcpm_pkg::WLEN_W-1:0]   wlen_q;
	logic [rcpm_pkg::CENTER_W-1:0] center_q;
	logic [rcpm_pkg::GAIN_W-1:0]   gain_q;
	logic [rcpm_pkg::VOLT_W-1:0]   volt_q;
	logic [rcpm_pkg::PF_W-1:0]     pf_q;

	logic [rcpm_pkg::SUM_W-1:0]    sum_q;
	logic [7:0]                    count_q;
	logic                          neg_q;
	logic [ACC_W-1:0]              acc_q;
	logic [ACC_W-1:0]              mcand_q;
	logic [MPL_W-1:0]              mplier_q;
	logic [rcpm_pkg::SUM_W-1:0]    dq_q;
	logic [8:0]                    drem_q;
	logic [8:0]                    divisor_q;
	logic [ACC_W-1:0]              rad_q;
	logic [21:0]                   srem_q;
	logic [19:0]                   root_q;
	logic [4:0]                    cnt_q;
	logic [rcpm_pkg::Q8_W-1:0]     q8_q;

	logic                          out_valid_q;
	logic [rcpm_pkg::AMPS_W-1:0]   amps_q;
	logic [rcpm_pkg::Q8_W-1:0]     irms_q;
	logic [rcpm_pkg::POWER_W-1:0]  power_q;

	// sample front end
	logic [10:0] twice;
	logic        neg;
	logic [10:0] diff;
	assign twice = {samples.sample, 1'b0};
	assign neg   = twice < center_q;
	assign diff  = neg ? (center_q - twice) : (twice - center_q);

	// shift-add multiplier step
	logic [ACC_W-1:0] acc_add;
	logic             mul_done;
	assign acc_add  = acc_q + (mplier_q[0] ? mcand_q : '0);
	assign mul_done = (mplier_q == '0);

	// floor of the arithmetic shift on a negative product
	logic [27:0] mag_sum;
	logic [17:0] mag;
	assign mag_sum = {1'b0, acc_q[26:0]} + (neg_q ? 28'd511 : 28'd0);
	assign mag     = mag_sum[26:9];

	// accumulation and window end
	logic [19:0] sq;
	logic [23:0] sum_ext;
	logic [rcpm_pkg::SUM_W-1:0] sum_sat;
	logic [8:0]  taken;
	logic [8:0]  target;
	assign sq      = acc_q[35:16];
	assign sum_ext = {1'b0, sum_q} + {4'b0, sq};
	assign sum_sat = sum_ext[23] ? '1 : sum_ext[22:0];
	assign taken   = {1'b0, count_q} + 9'd1;
	assign target  = (wlen_q == '0) ? 9'd256 : {1'b0, wlen_q};

	// restoring divide step
	logic [9:0] dshift;
	logic [9:0] dsub;
	logic       dge;
	logic [rcpm_pkg::SUM_W-1:0] dq_next;
	assign dshift  = {drem_q, dq_q[rcpm_pkg::SUM_W-1]};
	assign dsub    = dshift - {1'b0, divisor_q};
	assign dge     = dshift >= {1'b0, divisor_q};
	assign dq_next = {dq_q[rcpm_pkg::SUM_W-2:0], dge};

	// square root step, two radicand bits a cycle
	logic [23:0] sshift;
	logic [23:0] strial;
	logic [23:0] ssub;
	logic        sge;
	logic [19:0] root_next;
	logic [rcpm_pkg::Q8_W-1:0] q8_next;
	assign sshift    = {srem_q, rad_q[ACC_W-1:ACC_W-2]};
	assign strial    = {2'b0, root_q, 2'b01};
	assign ssub      = sshift - strial;
	assign sge       = sshift >= strial;
	assign root_next = {root_q[18:0], sge};
	assign q8_next   = (root_next[19:16] != 4'd0) ? '1 : root_next[15:0];

	logic [rcpm_pkg::POWER_W-1:0] power_sat;
	assign power_sat = acc_q[36] ? '1 : acc_q[35:18];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q   <= rcpm_pkg::WLEN_RST;
			center_q <= rcpm_pkg::CENTER_RST;
			gain_q   <= rcpm_pkg::GAIN_RST;
			volt_q   <= rcpm_pkg::VOLT_RST;
			pf_q     <= rcpm_pkg::PF_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				rcpm_pkg::REG_WINDOW_LEN:   wlen_q   <= cfg_data[rcpm_pkg::WLEN_W-1:0];
				rcpm_pkg::REG_CENTER_X2:    center_q <= cfg_data[rcpm_pkg::CENTER_W-1:0];
				rcpm_pkg::REG_GAIN_Q16:     gain_q   <= cfg_data[rcpm_pkg::GAIN_W-1:0];
				rcpm_pkg::REG_LINE_VOLTAGE: volt_q   <= cfg_data[rcpm_pkg::VOLT_W-1:0];
				rcpm_pkg::REG_POWER_FACTOR: pf_q     <= cfg_data[rcpm_pkg::PF_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (results.ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						neg_q    <= neg;
						acc_q    <= '0;
						mcand_q  <= {{(ACC_W-rcpm_pkg::GAIN_W){1'b0}}, gain_q};
						mplier_q <= {{(MPL_W-11){1'b0}}, diff};
						state_q  <= ST_MGAIN;
					end
				end
				ST_MGAIN: begin
					if (mul_done) begin
						acc_q    <= '0;
						mcand_q  <= {{(ACC_W-18){1'b0}}, mag};
						mplier_q <= mag;
						state_q  <= ST_SQUARE;
					end else begin
						acc_q    <= acc_add;
						mcand_q  <= {mcand_q[ACC_W-2:0], 1'b0};
						mplier_q <= {1'b0, mplier_q[MPL_W-1:1]};
					end
				end
				ST_SQUARE: begin
					if (mul_done) begin
						if (taken < target) begin
							sum_q   <= sum_sat;
							count_q <= taken[7:0];
							state_q <= ST_IDLE;
						end else begin
							sum_q     <= '0;
							count_q   <= '0;
							dq_q      <= sum_sat;
							drem_q    <= '0;
							divisor_q <= taken;
							cnt_q     <= 5'd22;
							state_q   <= ST_DIV;
						end
					end else begin
						acc_q    <= acc_add;
						mcand_q  <= {mcand_q[ACC_W-2:0], 1'b0};
						mplier_q <= {1'b0, mplier_q[MPL_W-1:1]};
					end
				end
				ST_DIV: begin
					dq_q   <= dq_next;
					drem_q <= dge ? dsub[8:0] : dshift[8:0];
					if (cnt_q == '0) begin
						rad_q   <= {1'b0, dq_next, 16'b0};
						srem_q  <= '0;
						root_q  <= '0;
						cnt_q   <= 5'd19;
						state_q <= ST_SQRT;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				ST_SQRT: begin
					rad_q  <= {rad_q[ACC_W-3:0], 2'b00};
					srem_q <= sge ? ssub[21:0] : sshift[21:0];
					root_q <= root_next;
					cnt_q  <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						q8_q     <= q8_next;
						acc_q    <= '0;
						mcand_q  <= {{(ACC_W-rcpm_pkg::Q8_W){1'b0}}, q8_next};
						mplier_q <= {{(MPL_W-rcpm_pkg::VOLT_W){1'b0}}, volt_q};
						state_q  <= ST_MVOLT;
					end
				end
				ST_MVOLT: begin
					if (mul_done) begin
						acc_q    <= '0;
						mcand_q  <= acc_q;
						mplier_q <= {{(MPL_W-rcpm_pkg::PF_W){1'b0}}, pf_q};
						state_q  <= ST_MPF;
					end else begin
						acc_q    <= acc_add;
						mcand_q  <= {mcand_q[ACC_W-2:0], 1'b0};
						mplier_q <= {1'b0, mplier_q[MPL_W-1:1]};
					end
				end
				ST_MPF: begin
					if (mul_done) begin
						state_q <= ST_OUT;
					end else begin
						acc_q    <= acc_add;
						mcand_q  <= {mcand_q[ACC_W-2:0], 1'b0};
						mplier_q <= {1'b0, mplier_q[MPL_W-1:1]};
					end
				end
				ST_OUT: begin
					if (!out_valid_q || results.ready) begin
						out_valid_q <= 1'b1;
						amps_q      <= q8_q[15:8];
						irms_q      <= q8_q;
						power_q     <= power_sat;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign samples.ready       = (state_q == ST_IDLE);
	assign results.valid       = out_valid_q;
	assign results.irms_amps   = amps_q;
	assign results.irms_q8     = irms_q;
	assign results.power_watts = power_q;

endmodule
`default_nettype wire

>>> rtl/rcpm_checker.sv
// Port-level checks of the RMS current and power meter core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rcpm_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic                              in_ready,
	input  wire logic                              out_valid,
	input  wire logic                              out_ready,
	input  wire logic [rcpm_pkg::AMPS_W-1:0]       irms_amps,
	input  wire logic [rcpm_pkg::Q8_W-1:0]         irms_q8,
	input  wire logic [rcpm_pkg::POWER_W-1:0]      power_watts
);

	// whole amperes are the integer part of the Q8 value
	a_amps_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (irms_amps == irms_q8[15:8]))
		else $error("irms_amps differs from irms_q8 integer part");

	// the core is not ready in the cycle after any sample transaction
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("core ready straight after a sample transaction");

	// a fresh result is only produced by a busy core
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped before transaction");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		($stable(irms_q8) && $stable(irms_amps) && $stable(power_watts)))
		else $error("result changed while stalled");

endmodule

bind rms_current_power_meter_core rcpm_checker u_rcpm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.irms_amps   (results.irms_amps),
	.irms_q8     (results.irms_q8),
	.power_watts (results.power_watts)
);
`default_nettype wire

>>> sim/rms_current_power_meter_core_tb.sv
// Self-checking testbench for the RMS current and power meter core.
`timescale 1ns / 1ps
module rms_current_power_meter_core_tb;

	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned SETTLE_CYCLES = 120;
	localparam longint unsigned SUM_SAT   = (64'd1 << rcpm_pkg::SUM_W) - 1;
	localparam longint unsigned Q8_SAT    = (64'd1 << rcpm_pkg::Q8_W) - 1;
	localparam longint unsigned AMPS_SAT  = (64'd1 << rcpm_pkg::AMPS_W) - 1;
	localparam longint unsigned POWER_SAT = (64'd1 << rcpm_pkg::POWER_W) - 1;

	typedef struct packed {
		logic [rcpm_pkg::AMPS_W-1:0]  amps;
		logic [rcpm_pkg::Q8_W-1:0]    q8;
		logic [rcpm_pkg::POWER_W-1:0] power;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [rcpm_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [rcpm_pkg::CFG_DATA_W-1:0] cfg_data;

	rcpm_sample_if adc_ch();
	rcpm_result_if rms_ch();

	rms_current_power_meter_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.samples(adc_ch),
		.results(rms_ch)
	);

	always #5 clk = ~clk;

	// meter settings and accumulator as the block should hold them
	logic [rcpm_pkg::WLEN_W-1:0]   cfg_window;
	logic [rcpm_pkg::CENTER_W-1:0] cfg_center;
	logic [rcpm_pkg::GAIN_W-1:0]   cfg_gain;
	logic [rcpm_pkg::VOLT_W-1:0]   cfg_volt;
	logic [rcpm_pkg::PF_W-1:0]     cfg_pf;
	logic [rcpm_pkg::SUM_W-1:0]    acc_sum;
	logic [rcpm_pkg::WLEN_W-1:0]   acc_count;

	logic [rcpm_pkg::SAMPLE_W-1:0] samples_queued[$];
	reading_t readings_due[$];

	int unsigned cycle_count = 0;
	int unsigned error_count = 0;
	int unsigned samples_taken = 0;
	int unsigned readings_checked = 0;
	int unsigned settings_applied = 0;
	int unsigned gap_left;
	int unsigned burst_left;
	int unsigned stall_mode;

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 20; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	task automatic accumulate_sample(input logic [rcpm_pkg::SAMPLE_W-1:0] s);
		longint unsigned twice, mag, sq, total, mean, root, pw;
		int unsigned target, taken;
		reading_t r;
		twice = 64'(s) << 1;
		if (twice >= cfg_center)
			mag = ((twice - cfg_center) * cfg_gain) >> 9;
		else
			mag = ((cfg_center - twice) * cfg_gain + 511) >> 9;
		sq = (mag * mag) >> 16;
		total = acc_sum + sq;
		if (total > SUM_SAT)
			total = SUM_SAT;
		target = (cfg_window == 0) ? 256 : cfg_window;
		taken = acc_count + 1;
		if (taken < target) begin
			acc_sum = total[rcpm_pkg::SUM_W-1:0];
			acc_count = taken[rcpm_pkg::WLEN_W-1:0];
		end else begin
			mean = total / taken;
			root = int_sqrt(mean << 16);
			if (root > Q8_SAT)
				root = Q8_SAT;
			r.q8 = root[rcpm_pkg::Q8_W-1:0];
			r.amps = ((root >> 8) > AMPS_SAT) ? AMPS_SAT[rcpm_pkg::AMPS_W-1:0] :
				8'(root >> 8);
			pw = (root * cfg_volt * cfg_pf) >> 18;
			if (pw > POWER_SAT)
				pw = POWER_SAT;
			r.power = pw[rcpm_pkg::POWER_W-1:0];
			readings_due.push_back(r);
			acc_sum = '0;
			acc_count = '0;
		end
	endtask

	task automatic write_reg(input rcpm_pkg::cfg_reg_t idx, input int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value[rcpm_pkg::CFG_DATA_W-1:0];
		case (idx)
			rcpm_pkg::REG_WINDOW_LEN:   cfg_window = value[rcpm_pkg::WLEN_W-1:0];
			rcpm_pkg::REG_CENTER_X2:    cfg_center = value[rcpm_pkg::CENTER_W-1:0];
			rcpm_pkg::REG_GAIN_Q16:     cfg_gain = value[rcpm_pkg::GAIN_W-1:0];
			rcpm_pkg::REG_LINE_VOLTAGE: cfg_volt = value[rcpm_pkg::VOLT_W-1:0];
			rcpm_pkg::REG_POWER_FACTOR: cfg_pf = value[rcpm_pkg::PF_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_meter(input int unsigned wlen, input int unsigned center,
		input int unsigned gain, input int unsigned volt, input int unsigned pf);
		write_reg(rcpm_pkg::REG_WINDOW_LEN, wlen);
		write_reg(rcpm_pkg::REG_CENTER_X2, center);
		write_reg(rcpm_pkg::REG_GAIN_Q16, gain);
		write_reg(rcpm_pkg::REG_LINE_VOLTAGE, volt);
		write_reg(rcpm_pkg::REG_POWER_FACTOR, pf);
		settings_applied++;
	endtask

	// sender holds off until every reading due has arrived and the core is quiet
	task automatic drain();
		while (samples_queued.size() != 0 || readings_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_samples(input int unsigned n);
		int s;
		for (int unsigned k = 0; k < n; k++) begin
			case ($urandom_range(0, 15))
				0: s = 0;
				1: s = 1023;
				2: begin
					s = int'(cfg_center / 2) + int'($urandom_range(0, 4)) - 2;
					if (s < 0)
						s = 0;
					if (s > 1023)
						s = 1023;
				end
				default: s = $urandom_range(0, 1023);
			endcase
			samples_queued.push_back(s[rcpm_pkg::SAMPLE_W-1:0]);
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("rms_current_power_meter_core: mismatch");
			$finish;
		end
	end

	// driver: bursts of samples with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			adc_ch.valid <= 1'b0;
			adc_ch.sample <= '0;
			gap_left <= 0;
			burst_left <= 4;
		end else begin
			if (adc_ch.valid && adc_ch.ready) begin
				accumulate_sample(adc_ch.sample);
				void'(samples_queued.pop_front());
				samples_taken++;
			end
			if (!adc_ch.valid || adc_ch.ready) begin
				if (gap_left != 0 || samples_queued.size() == 0) begin
					adc_ch.valid <= 1'b0;
					if (gap_left != 0)
						gap_left <= gap_left - 1;
				end else begin
					adc_ch.valid <= 1'b1;
					adc_ch.sample <= samples_queued[0];
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 48);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// monitor: checks each result transaction against the oldest reading due
	always @(posedge clk) begin
		reading_t want;
		if (!arst_n) begin
			rms_ch.ready <= 1'b0;
			stall_mode <= 0;
		end else begin
			if (rms_ch.valid && rms_ch.ready) begin
				if (readings_due.size() == 0) begin
					$error("unexpected reading: irms_amps %0d irms_q8 %0d power_watts %0d",
						rms_ch.irms_amps, rms_ch.irms_q8, rms_ch.power_watts);
					error_count++;
				end else begin
					want = readings_due.pop_front();
					readings_checked++;
					if (rms_ch.irms_amps !== want.amps) begin
						$error("irms_amps: expected %0d, got %0d", want.amps, rms_ch.irms_amps);
						error_count++;
					end
					if (rms_ch.irms_q8 !== want.q8) begin
						$error("irms_q8: expected %0d, got %0d", want.q8, rms_ch.irms_q8);
						error_count++;
					end
					if (rms_ch.power_watts !== want.power) begin
						$error("power_watts: expected %0d, got %0d", want.power,
							rms_ch.power_watts);
						error_count++;
					end
				end
			end
			if (cycle_count % 200 == 0)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: rms_ch.ready <= 1'b1;
				1: rms_ch.ready <= ($urandom_range(0, 1) == 1);
				2: rms_ch.ready <= (cycle_count % 4 == 0);
				default: rms_ch.ready <= (cycle_count % 40 >= 30);
			endcase
		end
	end

	initial begin
		int unsigned wlen, center, gain, volt, pf, n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = rcpm_pkg::REG_WINDOW_LEN;
		cfg_data = '0;
		adc_ch.valid = 1'b0;
		adc_ch.sample = '0;
		rms_ch.ready = 1'b0;
		cfg_window = rcpm_pkg::WLEN_RST;
		cfg_center = rcpm_pkg::CENTER_RST;
		cfg_gain = rcpm_pkg::GAIN_RST;
		cfg_volt = rcpm_pkg::VOLT_RST;
		cfg_pf = rcpm_pkg::PF_RST;
		acc_sum = '0;
		acc_count = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// single-sample windows at the sample extremes and around centre
		set_meter(1, 1023, 18123, 220, 942);
		samples_queued.push_back(10'd0);
		samples_queued.push_back(10'd1023);
		samples_queued.push_back(10'd511);
		samples_queued.push_back(10'd512);
		drain();
		// saturated RMS and power, full-scale positive current
		set_meter(1, 0, 65535, 1023, 2047);
		samples_queued.push_back(10'd1023);
		samples_queued.push_back(10'd0);
		drain();
		// centre above range: negative currents floor downwards
		write_reg(rcpm_pkg::REG_CENTER_X2, 2047);
		samples_queued.push_back(10'd0);
		samples_queued.push_back(10'd1023);
		drain();
		// accumulator saturation
		write_reg(rcpm_pkg::REG_CENTER_X2, 0);
		write_reg(rcpm_pkg::REG_WINDOW_LEN, 9);
		repeat (9) samples_queued.push_back(10'd1023);
		drain();
		// window shortened below the samples already taken
		set_meter(8, 1023, 18123, 220, 942);
		queue_samples(5);
		drain();
		write_reg(rcpm_pkg::REG_WINDOW_LEN, 3);
		queue_samples(1);
		drain();

		for (int p = 0; p < 10; p++) begin
			wlen = $urandom_range(1, 12);
			center = $urandom_range(0, 2047);
			gain = $urandom_range(0, 65535);
			volt = $urandom_range(0, 1023);
			pf = $urandom_range(0, 2047);
			n = 60;
			case (p)
				0: begin
					wlen = 0;
					n = 300;
				end
				1: begin
					wlen = 5;
					gain = 0;
					volt = 0;
					pf = 0;
				end
				2: begin
					wlen = 255;
					center = 2047;
					gain = 65535;
					volt = 1023;
					pf = 2047;
					n = 260;
				end
				default: ;
			endcase
			set_meter(wlen, center, gain, volt, pf);
			queue_samples(n / 2);
			drain();
			queue_samples(n - n / 2);
			drain();
		end

		$display("covered %0d ADC samples and %0d RMS readings over %0d meter settings",
			samples_taken, readings_checked, settings_applied);
		$display("windows of 1 to 256 samples, saturation and mid-window shortening included");
		if (error_count == 0)
			$display("rms_current_power_meter_core: match");
		else
			$display("rms_current_power_meter_core: mismatch");
		$finish;
	end

endmodule

>>> sim.f
rtl/rcpm_pkg.sv
rtl/rcpm_if.sv
rtl/rms_current_power_meter_core.sv
rtl/rcpm_checker.sv
sim/rms_current_power_meter_core_tb.sv
